### hdl/hfti_pkg.sv
// ----------------------------------------------------------------------------
// hfti_pkg: shared types and constants for the heightfield interpolator
// Widths of the transaction fields, store geometry, command and register
// codes, and the structs passed between the pipeline modules.
// ----------------------------------------------------------------------------
package hfti_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int ADDR_W      = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int BANK_AW     = ADDR_W - 1;
  localparam int BANK_DEPTH  = 2 ** BANK_AW;

  localparam int CFG_W       = 9;
  localparam int POS_W       = 17;
  localparam int FRAC_W      = 8;
  localparam int CELL_W      = POS_W - 1 - FRAC_W;
  localparam int INDEX_W     = 16;
  localparam int H_W         = 8;
  localparam int HV_W        = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [HV_W-1:0] HEIGHT_MAX = 16'd65280;
  localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } hfti_cmd_t;

  typedef enum logic {
    REG_GRID_WIDTH = 1'b0,
    REG_GRID_DEPTH = 1'b1
  } hfti_reg_t;

  // Store access request: addr_a is the (x,z) corner, addr_b the (x,z+1) one.
  typedef struct packed {
    logic              is_query;
    logic              in_range;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    logic [H_W-1:0]    load_height;
  } hfti_req_t;

  typedef struct packed {
    logic              in_range;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    logic [H_W-1:0]    h00;
    logic [H_W-1:0]    h10;
    logic [H_W-1:0]    h01;
    logic [H_W-1:0]    h11;
  } hfti_corner_t;

endpackage

### hdl/hfti_if.sv
// ----------------------------------------------------------------------------
// hfti_if: valid/ready channel interfaces of the heightfield interpolator
// One interface for the command channel and one for the result channel.
// ----------------------------------------------------------------------------
interface hfti_in_if;
  import hfti_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_z;
  logic [INDEX_W-1:0]      load_index;
  logic [H_W-1:0]          load_height;

  modport source (output valid, command, pos_x, pos_z, load_index, load_height,
                  input ready);
  modport sink   (input valid, command, pos_x, pos_z, load_index, load_height,
                  output ready);
endinterface

interface hfti_out_if;
  import hfti_pkg::*;

  logic            valid;
  logic            ready;
  logic [HV_W-1:0] height_value;
  logic            in_range;

  modport source (output valid, height_value, in_range, input ready);
  modport sink   (input valid, height_value, in_range, output ready);
endinterface

### hdl/hfti_addr.sv
// ----------------------------------------------------------------------------
// hfti_addr: decode and address generation stages
// Stage 1 checks the range and forms width*z; stage 2 forms the two row
// base addresses of the cell, or passes the load address through.
// ----------------------------------------------------------------------------
module hfti_addr (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [hfti_pkg::CFG_W-1:0]       grid_width,
  input  logic [hfti_pkg::CFG_W-1:0]       grid_depth,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic signed [hfti_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [hfti_pkg::POS_W-1:0] in_pos_z,
  input  logic [hfti_pkg::INDEX_W-1:0]     in_load_index,
  input  logic [hfti_pkg::H_W-1:0]         in_load_height,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hfti_pkg::hfti_req_t              out_req
);
  import hfti_pkg::*;

  // Stage 1 registers
  logic                      s1_valid_r;
  logic                      s1_query_r;
  logic                      s1_ok_r;
  logic [CFG_W+CELL_W-1:0]   s1_prod_r;
  logic [CELL_W-1:0]         s1_cx_r;
  logic [FRAC_W-1:0]         s1_fx_r;
  logic [FRAC_W-1:0]         s1_fz_r;
  logic [INDEX_W-1:0]        s1_index_r;
  logic [H_W-1:0]            s1_height_r;

  // Stage 2 registers
  logic                      s2_valid_r;
  hfti_req_t                 s2_req_r;
  hfti_req_t                 s2_req_nxt;

  logic                      s1_rdy;
  logic                      s2_rdy;
  logic [CELL_W-1:0]         cx;
  logic [CELL_W-1:0]         cz;
  logic                      ok;
  logic [ADDR_W-1:0]         base_a;

  assign cx = in_pos_x[POS_W-2:FRAC_W];
  assign cz = in_pos_z[POS_W-2:FRAC_W];

  // A cell index plus two must not pass the grid side; this also rejects
  // grids narrower than two samples.
  always_comb begin
    ok = !in_pos_x[POS_W-1] && !in_pos_z[POS_W-1] &&
         (({2'b00, cx} + 10'd2) <= {1'b0, grid_width}) &&
         (({2'b00, cz} + 10'd2) <= {1'b0, grid_depth});
  end

  assign s2_rdy   = !s2_valid_r || out_ready;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_query_r  <= (in_command == CMD_QUERY);
      s1_ok_r     <= ok;
      s1_prod_r   <= grid_width * cz;
      s1_cx_r     <= cx;
      s1_fx_r     <= in_pos_x[FRAC_W-1:0];
      s1_fz_r     <= in_pos_z[FRAC_W-1:0];
      s1_index_r  <= in_load_index;
      s1_height_r <= in_load_height;
    end
  end

  always_comb begin
    base_a = s1_prod_r[ADDR_W-1:0] + {{(ADDR_W-CELL_W){1'b0}}, s1_cx_r};
    s2_req_nxt.is_query    = s1_query_r;
    s2_req_nxt.in_range    = s1_ok_r;
    s2_req_nxt.addr_a      = s1_query_r ? base_a : s1_index_r[ADDR_W-1:0];
    s2_req_nxt.addr_b      = base_a + {{(ADDR_W-CFG_W){1'b0}}, grid_width};
    s2_req_nxt.fx          = s1_fx_r;
    s2_req_nxt.fz          = s1_fz_r;
    s2_req_nxt.load_height = s1_height_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_valid_r) begin
      s2_req_r <= s2_req_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_req   = s2_req_r;

endmodule

### hdl/hfti_store.sv
// ----------------------------------------------------------------------------
// hfti_store: banked height sample store
// Two copies of the store, each split into even and odd address banks, so
// the four corners of a cell are read in the same cycle with one read per bank.
// ----------------------------------------------------------------------------
module hfti_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hfti_pkg::hfti_req_t    in_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hfti_pkg::hfti_corner_t out_corner
);
  import hfti_pkg::*;

  localparam int NUM_BANKS = 4;

  logic                 fire;
  logic                 load_fire;
  logic                 query_fire;
  logic [BANK_AW-1:0]   rd_addr [NUM_BANKS];
  logic [H_W-1:0]       rd_data_r [NUM_BANKS];
  logic [BANK_AW-1:0]   wr_addr;
  logic                 wr_odd;

  logic                 s4_valid_r;
  logic                 a_odd_r;
  logic                 b_odd_r;
  logic                 s4_range_r;
  logic [FRAC_W-1:0]    s4_fx_r;
  logic [FRAC_W-1:0]    s4_fz_r;

  assign in_ready   = !s4_valid_r || out_ready;
  assign fire       = in_valid && in_ready;
  assign load_fire  = fire && !in_req.is_query;
  assign query_fire = fire && in_req.is_query;
  assign wr_addr    = in_req.addr_a[ADDR_W-1:1];
  assign wr_odd     = in_req.addr_a[0];

  // Bank index: bit 1 picks the copy (row a or row b), bit 0 the parity.
  // For a pair starting at an odd address the even word is the next one.
  always_comb begin
    rd_addr[0] = in_req.addr_a[ADDR_W-1:1] + {{(BANK_AW-1){1'b0}}, in_req.addr_a[0]};
    rd_addr[1] = in_req.addr_a[ADDR_W-1:1];
    rd_addr[2] = in_req.addr_b[ADDR_W-1:1] + {{(BANK_AW-1){1'b0}}, in_req.addr_b[0]};
    rd_addr[3] = in_req.addr_b[ADDR_W-1:1];
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    logic [H_W-1:0] mem [BANK_DEPTH];
    logic           we;

    assign we = load_fire && (wr_odd == 1'(g % 2));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_addr] <= in_req.load_height;
      end
      if (query_fire) begin
        rd_data_r[g] <= mem[rd_addr[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (in_ready) begin
      s4_valid_r <= in_valid && in_req.is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (query_fire) begin
      a_odd_r    <= in_req.addr_a[0];
      b_odd_r    <= in_req.addr_b[0];
      s4_range_r <= in_req.in_range;
      s4_fx_r    <= in_req.fx;
      s4_fz_r    <= in_req.fz;
    end
  end

  always_comb begin
    out_corner.in_range = s4_range_r;
    out_corner.fx       = s4_fx_r;
    out_corner.fz       = s4_fz_r;
    out_corner.h00      = a_odd_r ? rd_data_r[1] : rd_data_r[0];
    out_corner.h10      = a_odd_r ? rd_data_r[0] : rd_data_r[1];
    out_corner.h01      = b_odd_r ? rd_data_r[3] : rd_data_r[2];
    out_corner.h11      = b_odd_r ? rd_data_r[2] : rd_data_r[3];
  end

  assign out_valid = s4_valid_r;

endmodule

### hdl/hfti_blend.sv
// ----------------------------------------------------------------------------
// hfti_blend: triangle selection and linear interpolation
// Stage 5 picks the triangle and forms the two weighted differences;
// stage 6 sums them onto the anchor corner and holds the result.
// ----------------------------------------------------------------------------
module hfti_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hfti_pkg::hfti_corner_t        in_corner,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hfti_pkg::HV_W-1:0]     out_height_value,
  output logic                          out_in_range
);
  import hfti_pkg::*;

  localparam int DIFF_W = H_W + 1;
  localparam int WGT_W  = FRAC_W + 1;
  localparam int PROD_W = DIFF_W + WGT_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [WGT_W-1:0] ONE = WGT_W'(1 << FRAC_W);

  logic                      s5_valid_r;
  logic                      s5_range_r;
  logic [H_W-1:0]            s5_base_r;
  logic signed [PROD_W-1:0]  s5_pa_r;
  logic signed [PROD_W-1:0]  s5_pb_r;

  logic                      s6_valid_r;
  logic [HV_W-1:0]           s6_height_r;
  logic                      s6_range_r;
  logic [HV_W-1:0]           s6_height_nxt;

  logic                      s5_rdy;
  logic                      s6_rdy;
  logic                      upper;
  logic [H_W-1:0]            base;
  logic signed [DIFF_W-1:0]  da;
  logic signed [DIFF_W-1:0]  db;
  logic [WGT_W-1:0]          wa;
  logic [WGT_W-1:0]          wb;
  logic signed [SUM_W-1:0]   sum;

  assign s6_rdy   = !s6_valid_r || out_ready;
  assign s5_rdy   = !s5_valid_r || s6_rdy;
  assign in_ready = s5_rdy;

  // The upper triangle is anchored at (x+1,z+1) with complementary weights.
  always_comb begin
    upper = ({1'b0, in_corner.fx} + {1'b0, in_corner.fz}) > ONE;
    if (upper) begin
      base = in_corner.h11;
      da   = $signed({1'b0, in_corner.h01}) - $signed({1'b0, in_corner.h11});
      db   = $signed({1'b0, in_corner.h10}) - $signed({1'b0, in_corner.h11});
      wa   = ONE - {1'b0, in_corner.fx};
      wb   = ONE - {1'b0, in_corner.fz};
    end else begin
      base = in_corner.h00;
      da   = $signed({1'b0, in_corner.h10}) - $signed({1'b0, in_corner.h00});
      db   = $signed({1'b0, in_corner.h01}) - $signed({1'b0, in_corner.h00});
      wa   = {1'b0, in_corner.fx};
      wb   = {1'b0, in_corner.fz};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && in_valid) begin
      s5_range_r <= in_corner.in_range;
      s5_base_r  <= base;
      s5_pa_r    <= da * $signed({1'b0, wa});
      s5_pb_r    <= db * $signed({1'b0, wb});
    end
  end

  always_comb begin
    sum = $signed({{(SUM_W-H_W-FRAC_W){1'b0}}, s5_base_r, {FRAC_W{1'b0}}}) +
          $signed({s5_pa_r[PROD_W-1], s5_pa_r}) +
          $signed({s5_pb_r[PROD_W-1], s5_pb_r});
    if (!s5_range_r || sum[SUM_W-1]) begin
      s6_height_nxt = '0;
    end else if (sum[SUM_W-2:0] > {{(SUM_W-1-HV_W){1'b0}}, HEIGHT_MAX}) begin
      s6_height_nxt = HEIGHT_MAX;
    end else begin
      s6_height_nxt = sum[HV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (s6_rdy) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_rdy && s5_valid_r) begin
      s6_height_r <= s6_height_nxt;
      s6_range_r  <= s5_range_r;
    end
  end

  assign out_valid        = s6_valid_r;
  assign out_height_value = s6_height_r;
  assign out_in_range     = s6_range_r;

endmodule

### hdl/heightfield_triangle_interp_top.sv
// ----------------------------------------------------------------------------
// heightfield_triangle_interp_top: heightfield triangle interpolator
// Stores a grid of 8-bit height samples and returns Q8.8 heights for
// Q9.8 positions by interpolating over one triangle of the cell.
//
// Usage:
//   in_ch carries transactions of two kinds. A load (command 0) writes
//   load_height at load_index and gives no result. A query (command 1)
//   gives one result on out_ch: height_value and in_range, with
//   height_value zero when the position is negative or past the grid.
//   The APB port holds grid_width (byte address 0) and grid_depth (4);
//   write them only while no transaction is in flight.
//   Throughput is one transaction per cycle while out_ch is not stalled.
//   A query result passes five register stages: decode, address, store
//   read, weighting, sum. The four corners come from four single-port
//   banks (two copies split by address parity), so the store never
//   limits rate.
//   Each stage holds its own valid bit; when out_ch stalls the pipeline
//   fills its bubbles and then holds, dropping nothing.
//   Synchronous reset empties the pipeline and sets both grid sides to
//   256; the store itself is not cleared, so the user must see that every
//   cell is loaded before any query reads it; the block does not check it.
// ----------------------------------------------------------------------------
module heightfield_triangle_interp_top (
  input  logic                            clk,
  input  logic                            rst_n,
  hfti_in_if.sink                         in_ch,
  hfti_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hfti_pkg::PADDR_W-1:0]    paddr,
  input  logic [hfti_pkg::PDATA_W-1:0]    pwdata,
  output logic [hfti_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import hfti_pkg::*;

  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_depth_r;
  hfti_reg_t        reg_sel;
  logic             cfg_write;

  logic             addr_valid;
  logic             addr_ready;
  hfti_req_t        addr_req;
  logic             corner_valid;
  logic             corner_ready;
  hfti_corner_t     corner;

  assign pready    = 1'b1;
  assign reg_sel   = hfti_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_RESET;
      grid_depth_r <= GRID_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_GRID_WIDTH: grid_width_r <= pwdata[CFG_W-1:0];
        REG_GRID_DEPTH: grid_depth_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_WIDTH: prdata = {{(PDATA_W-CFG_W){1'b0}}, grid_width_r};
      REG_GRID_DEPTH: prdata = {{(PDATA_W-CFG_W){1'b0}}, grid_depth_r};
      default:        prdata = '0;
    endcase
  end

  hfti_addr u_addr (
    .clk            (clk),
    .rst_n          (rst_n),
    .grid_width     (grid_width_r),
    .grid_depth     (grid_depth_r),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_command     (in_ch.command),
    .in_pos_x       (in_ch.pos_x),
    .in_pos_z       (in_ch.pos_z),
    .in_load_index  (in_ch.load_index),
    .in_load_height (in_ch.load_height),
    .out_valid      (addr_valid),
    .out_ready      (addr_ready),
    .out_req        (addr_req)
  );

  hfti_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (addr_valid),
    .in_ready   (addr_ready),
    .in_req     (addr_req),
    .out_valid  (corner_valid),
    .out_ready  (corner_ready),
    .out_corner (corner)
  );

  hfti_blend u_blend (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (corner_valid),
    .in_ready         (corner_ready),
    .in_corner        (corner),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_height_value (out_ch.height_value),
    .out_in_range     (out_ch.in_range)
  );

endmodule

### dv/heightfield_triangle_interp_top_test.sv
// ----------------------------------------------------------------------------
// heightfield_triangle_interp_top_test: self-checking bench for the
// heightfield triangle interpolator
// Loads height samples and fires position queries through the valid/ready
// channels, and moves the grid sides over the APB port between phases.
// Each query result is checked against a local model of the store and of
// the triangle interpolation, or, for a typed directed entry, against the
// value in its table. A short directed table comes first, then random
// traffic over many grid shapes and three back-pressure profiles. Every
// cell that a query reads is loaded before that query is sent.
module heightfield_triangle_interp_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hfti_pkg::*;

  localparam int N_DIRECTED   = 22;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 190;
  localparam int SETTLE_CYC   = 8;
  localparam int STORE_DEPTH  = 1 << ADDR_W;

  typedef struct {
    hfti_cmd_t         cmd;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  pz;
    logic [INDEX_W-1:0] idx;
    logic [H_W-1:0]    h;
    bit                typed;
    logic [HV_W-1:0]   t_height;
    logic              t_in_range;
  } grid_op_t;

  typedef struct {
    logic [HV_W-1:0] height;
    logic            in_range;
  } height_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  hfti_in_if  in_ch();
  hfti_out_if out_ch();

  heightfield_triangle_interp_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the grid sides and of the height store.
  logic [CFG_W-1:0] grid_w;
  logic [CFG_W-1:0] grid_d;
  logic [H_W-1:0]   height_mem [STORE_DEPTH];
  // Cells already loaded by the stimulus, tracked when an item is issued.
  bit               cell_loaded [STORE_DEPTH];

  height_result_t pending_heights[$];

  int mismatches;
  int n_loads;
  int n_queries;
  int n_results;
  int n_in_range;
  int n_issued;
  int tx_idle_pct;
  int rx_idle_pct;
  int tx_calm;
  int rx_calm;

  int phase_w [N_PHASES] = '{256, 2, 511, 17, 0, 256, 3, 200, 1, 511};
  int phase_d [N_PHASES] = '{256, 2, 3, 40, 256, 1, 511, 130, 0, 511};

  grid_op_t directed_ops [N_DIRECTED] = '{
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd0,     8'd255,  1'b0, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd1,     8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd256,   8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd257,   8'd255,  1'b0, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h00000, 17'h00000, 16'hFFFF,  8'hFF,   1'b1, 16'd65280, 1'b1},
    '{CMD_QUERY, 17'h000FF, 17'h00000, 16'd0,     8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h00080, 17'h00080, 16'd0,     8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h00081, 17'h00080, 16'd0,     8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h000FF, 17'h000FF, 16'd0,     8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h1FFFF, 17'h1FFFF, 16'd65278, 8'h5A,   1'b0, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd65279, 8'hFF,   1'b0, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd65534, 8'h00,   1'b0, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd65535, 8'hA5,   1'b0, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h0FEFF, 17'h0FEFF, 16'd0,     8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h0FE00, 17'h0FE00, 16'd0,     8'd0,    1'b1, 16'h5A00,  1'b1},
    '{CMD_QUERY, 17'h1FFFF, 17'h00000, 16'd0,     8'd0,    1'b1, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h00000, 17'h10000, 16'd0,     8'd0,    1'b1, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h0FF00, 17'h00000, 16'd0,     8'd0,    1'b1, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h00000, 17'h0FFFF, 16'd0,     8'd0,    1'b1, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h0FFFF, 17'h0FFFF, 16'd0,     8'd0,    1'b1, 16'd0,     1'b0},
    '{CMD_LOAD,  17'h00000, 17'h00000, 16'd0,     8'd0,    1'b0, 16'd0,     1'b0},
    '{CMD_QUERY, 17'h00000, 17'h00000, 16'd0,     8'd0,    1'b1, 16'd0,     1'b1}
  };

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Works out which four store cells a position reads. The corners are
  // ordered h00, h10, h01, h11; hit is low when the position is negative,
  // past the grid, or the grid is too small to hold a cell.
  function automatic void find_corners(input logic [POS_W-1:0] px,
                                       input logic [POS_W-1:0] pz,
                                       output bit hit,
                                       output logic [3:0][ADDR_W-1:0] corner);
    int w;
    int d;
    int cx;
    int cz;
    int base0;
    int base1;
    hit = 1'b0;
    corner = '0;
    w = int'(grid_w);
    d = int'(grid_d);
    if (px[POS_W-1] || pz[POS_W-1]) return;
    if (w < 2 || d < 2) return;
    cx = int'(px[POS_W-2:FRAC_W]);
    cz = int'(pz[POS_W-2:FRAC_W]);
    if (cx > w - 2 || cz > d - 2) return;
    base0 = w * cz + cx;
    base1 = w * (cz + 1) + cx;
    corner[0] = ADDR_W'(base0);
    corner[1] = ADDR_W'(base0 + 1);
    corner[2] = ADDR_W'(base1);
    corner[3] = ADDR_W'(base1 + 1);
    hit = 1'b1;
  endfunction

  function automatic height_result_t predict_height(input logic [POS_W-1:0] px,
                                                    input logic [POS_W-1:0] pz);
    height_result_t res;
    bit hit;
    logic [3:0][ADDR_W-1:0] corner;
    int h00;
    int h10;
    int h01;
    int h11;
    int fx;
    int fz;
    int r;
    res.height = '0;
    res.in_range = 1'b0;
    find_corners(px, pz, hit, corner);
    if (!hit) return res;
    h00 = int'(height_mem[corner[0]]);
    h10 = int'(height_mem[corner[1]]);
    h01 = int'(height_mem[corner[2]]);
    h11 = int'(height_mem[corner[3]]);
    fx = int'(px[FRAC_W-1:0]);
    fz = int'(pz[FRAC_W-1:0]);
    // Lower triangle is anchored at h00, the upper one at h11.
    if (fx + fz <= 256) begin
      r = h00 * 256 + (h10 - h00) * fx + (h01 - h00) * fz;
    end else begin
      r = h11 * 256 + (h01 - h11) * (256 - fx) + (h10 - h11) * (256 - fz);
    end
    if (r < 0) r = 0;
    if (r > int'(HEIGHT_MAX)) r = int'(HEIGHT_MAX);
    res.height = HV_W'(r);
    res.in_range = 1'b1;
    return res;
  endfunction

  function automatic grid_op_t untyped_op(input hfti_cmd_t cmd,
                                          input logic [POS_W-1:0] px,
                                          input logic [POS_W-1:0] pz,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic [H_W-1:0] h);
    grid_op_t op;
    op = '{cmd, px, pz, idx, h, 1'b0, '0, 1'b0};
    return op;
  endfunction

  function automatic bit tx_gap();
    if (tx_calm > 0) begin
      tx_calm--;
      return 1'b0;
    end
    if ($urandom_range(99) < 2) begin
      tx_calm = $urandom_range(40, 10);
      return 1'b0;
    end
    return $urandom_range(99) < tx_idle_pct;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next transaction can follow back to back.
  task automatic issue_op(input grid_op_t op);
    height_result_t res;
    if (op.cmd == CMD_LOAD) cell_loaded[op.idx] = 1'b1;
    while (tx_gap()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= op.cmd;
    in_ch.pos_x       <= op.px;
    in_ch.pos_z       <= op.pz;
    in_ch.load_index  <= op.idx;
    in_ch.load_height <= op.h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_issued++;
    if (op.cmd == CMD_LOAD) begin
      height_mem[op.idx] = op.h;
      n_loads++;
    end else begin
      res = predict_height(op.px, op.pz);
      if (op.typed) begin
        res.height   = op.t_height;
        res.in_range = op.t_in_range;
      end
      pending_heights.push_back(res);
      n_queries++;
    end
    @(negedge clk);
  endtask

  // Loads any corner the query would read that holds no sample yet, then sends the query.
  task automatic query_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
    bit hit;
    logic [3:0][ADDR_W-1:0] corner;
    find_corners(px, pz, hit, corner);
    if (hit) begin
      for (int k = 0; k < 4; k++) begin
        if (!cell_loaded[corner[k]]) begin
          issue_op(untyped_op(CMD_LOAD, POS_W'($urandom), POS_W'($urandom),
                              INDEX_W'(corner[k]), H_W'($urandom)));
        end
      end
    end
    issue_op(untyped_op(CMD_QUERY, px, pz, INDEX_W'($urandom), H_W'($urandom)));
  endtask

  function automatic logic [FRAC_W-1:0] pick_frac();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 8'h80;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  task automatic run_random(input int count);
    int first;
    int kind;
    int maxcx;
    int maxcz;
    int cx;
    int cz;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    first = n_issued;
    maxcx = (int'(grid_w) - 2 > 255) ? 255 : int'(grid_w) - 2;
    maxcz = (int'(grid_d) - 2 > 255) ? 255 : int'(grid_d) - 2;
    while (n_issued - first < count) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        issue_op(untyped_op(CMD_LOAD, POS_W'($urandom), POS_W'($urandom),
                            INDEX_W'($urandom), H_W'($urandom)));
      end else if (kind < 28 || maxcx < 0 || maxcz < 0) begin
        query_at(POS_W'($urandom), POS_W'($urandom));
      end else if (kind < 40) begin
        // Near the far rim of the grid, on either side of the last cell.
        cx = maxcx + $urandom_range(1);
        cz = maxcz + $urandom_range(1);
        if (cx > 255) cx = 255;
        if (cz > 255) cz = 255;
        if ($urandom_range(1) == 0) cz = $urandom_range(maxcz);
        query_at({1'b0, CELL_W'(cx), pick_frac()}, {1'b0, CELL_W'(cz), pick_frac()});
      end else begin
        cx = $urandom_range(maxcx);
        cz = $urandom_range(maxcz);
        fx = FRAC_W'($urandom);
        fz = FRAC_W'($urandom);
        // Put some points exactly on the diagonal between the triangles.
        if ($urandom_range(3) == 0 && fx != '0) fz = FRAC_W'(256 - int'(fx));
        query_at({1'b0, CELL_W'(cx), fx}, {1'b0, CELL_W'(cz), fz});
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic apb_access(input hfti_reg_t r, input bit wr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(4 * int'(r));
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input hfti_reg_t r, input logic [CFG_W-1:0] want);
    logic [PDATA_W-1:0] rdata;
    apb_access(r, 1'b0, '0, rdata);
    if (rdata !== PDATA_W'(want)) begin
      report_mismatch($sformatf("%s reads %0d, expected %0d", r.name(), rdata, want));
    end
  endtask

  task automatic set_grid(input int w, input int d);
    logic [PDATA_W-1:0] rdata;
    apb_access(REG_GRID_WIDTH, 1'b1, PDATA_W'(w), rdata);
    apb_access(REG_GRID_DEPTH, 1'b1, PDATA_W'(d), rdata);
    grid_w = CFG_W'(w);
    grid_d = CFG_W'(d);
    check_reg(REG_GRID_WIDTH, grid_w);
    check_reg(REG_GRID_DEPTH, grid_d);
  endtask

  // Loads give no result, so the last one may still be in the pipeline
  // when the queue empties; give it the pipeline depth and some margin.
  task automatic wait_idle();
    while (pending_heights.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_calm > 0) begin
      rx_calm = rx_calm - 1;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(99) < 2) begin
      rx_calm = $urandom_range(40, 10);
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    height_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected result: height %0d in_range %0b",
                                  out_ch.height_value, out_ch.in_range));
      end else begin
        want = pending_heights.pop_front();
        n_results++;
        if (want.in_range) n_in_range++;
        if (out_ch.height_value !== want.height) begin
          report_mismatch($sformatf("result %0d: height_value %0d, expected %0d",
                                    n_results, out_ch.height_value, want.height));
        end
        if (out_ch.in_range !== want.in_range) begin
          report_mismatch($sformatf("result %0d: in_range %0b, expected %0b",
                                    n_results, out_ch.in_range, want.in_range));
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("Timeout: the run did not complete in time.");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int waited;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_LOAD;
    in_ch.pos_x       = '0;
    in_ch.pos_z       = '0;
    in_ch.load_index  = '0;
    in_ch.load_height = '0;
    out_ch.ready      = 1'b0;
    grid_w            = GRID_RESET;
    grid_d            = GRID_RESET;
    tx_idle_pct       = 31;
    rx_idle_pct       = 88;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_reg(REG_GRID_WIDTH, GRID_RESET);
    check_reg(REG_GRID_DEPTH, GRID_RESET);
    for (int i = 0; i < N_DIRECTED; i++) issue_op(directed_ops[i]);
    in_ch.valid <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 31;
        rx_idle_pct = 88;
      end else if (p < 7) begin
        tx_idle_pct = 88;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p > 0) begin
        wait_idle();
        set_grid(phase_w[p], phase_d[p]);
      end
      run_random(PHASE_ITEMS);
    end

    waited = 0;
    while (pending_heights.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_heights.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_heights.size()));
    end

    $display("Run covered %0d loads and %0d queries over %0d grid shapes.",
             n_loads, n_queries, N_PHASES);
    $display("Checked %0d query results, %0d of them inside the grid; %0d mismatches.",
             n_results, n_in_range, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hdl/hfti_pkg.sv
hdl/hfti_if.sv
hdl/hfti_addr.sv
hdl/hfti_store.sv
hdl/hfti_blend.sv
hdl/heightfield_triangle_interp_top.sv
dv/heightfield_triangle_interp_top_test.sv
